// File: src/trimmed_mean_sample_averager_unit_defines.svh
// assertion macros for the trimmed mean sample averager
`ifndef TRIMMED_MEAN_SAMPLE_AVERAGER_UNIT_DEFINES_SVH
`define TRIMMED_MEAN_SAMPLE_AVERAGER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TMSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TMSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tmsa_pkg.sv
// shared constants and types of the trimmed mean sample averager
package tmsa_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int MAX_SAMPLES = 64;
  localparam int SUM_W       = 16;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int DIVR_W      = $clog2(MAX_SAMPLES);
  localparam int MIN_W       = SAMPLE_BITS + 1;
  localparam int TRIM_W      = MIN_W + 1;
  localparam int SPA_W       = 7;
  localparam int SETTLE_W    = 16;
  localparam int CFG_W       = 16;
  localparam int IDX_W       = 2;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  localparam logic [SPA_W-1:0]       SPA_RESET       = SPA_W'(52);
  localparam logic [SPA_W-1:0]       SPA_MIN         = SPA_W'(3);
  localparam logic [SPA_W-1:0]       SPA_MAX         = SPA_W'(MAX_SAMPLES);
  localparam logic [MIN_W-1:0]       MIN_START_RESET = MIN_W'(1) << SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] MAX_START_RESET = '0;
  localparam logic [SETTLE_W-1:0]    SETTLE_RESET    = '0;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK     = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_SPA,
    REG_MIN_START,
    REG_MAX_START,
    REG_SETTLE
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: src/trimmed_mean_sample_averager_unit.sv
// trimmed mean sample averager top level
//
// Input channel (in_valid/in_ready) carries one converter sample and the
// sensing_on flag per item. Every input item yields exactly one output item
// (out_valid/out_ready) with the held average and an update flag.
// With sensing off the running block is cleared and the settle countdown is
// reloaded; during settling samples are skipped.
// An item that does not close a block gives its result in the cycle after
// acceptance when the output register is free, so such items stream at one
// per cycle. An item that closes a block runs the trimmed sum through the
// bit-serial divider, one quotient bit per cycle, passing through S_PREP,
// S_DIV and S_OUT before the next item is taken; in_ready stays low
// meanwhile. The output register holds its item until out_ready; while it
// is full a new result waits in a holding state and no further input is
// taken. Configuration is written through cfg_we/cfg_index/cfg_data by
// the user only while the block is idle; the block does not enforce it.
// Synchronous reset restores register defaults, clears the running block,
// the held average and the output register.
`include "trimmed_mean_sample_averager_unit_defines.svh"

module trimmed_mean_sample_averager_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tmsa_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                             sensing_on,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tmsa_pkg::SAMPLE_BITS-1:0] average,
  output logic                             average_updated,
  input  logic                             cfg_we,
  input  logic [tmsa_pkg::IDX_W-1:0]       cfg_index,
  input  logic [tmsa_pkg::CFG_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic [tmsa_pkg::SPA_W-1:0]       samples_per_average;
  logic [tmsa_pkg::MIN_W-1:0]       min_start;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] max_start;
  logic [tmsa_pkg::SETTLE_W-1:0]    settle_ticks;

  logic [tmsa_pkg::SUM_W-1:0]       running_sum;
  logic [tmsa_pkg::CNT_W-1:0]       samples_taken;
  logic [tmsa_pkg::MIN_W-1:0]       running_min;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] running_max;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] held_average;
  logic [tmsa_pkg::SETTLE_W-1:0]    settle_left;
  logic                             pend_updated;

  logic [tmsa_pkg::SPA_W-1:0]       spa_clamped;
  logic [tmsa_pkg::CNT_W-1:0]       block_n;
  logic                             accept;
  logic                             slot_free;
  logic                             take;
  logic [tmsa_pkg::SUM_W:0]         sum_wide;
  logic [tmsa_pkg::SUM_W-1:0]       sum_next;
  logic [tmsa_pkg::CNT_W-1:0]       cnt_next;
  logic [tmsa_pkg::MIN_W-1:0]       min_next;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] max_next;
  logic                             complete;
  logic [tmsa_pkg::TRIM_W-1:0]      trim;
  logic [tmsa_pkg::SUM_W-1:0]       trim_ext;
  logic [tmsa_pkg::SUM_W-1:0]       diff;
  logic [tmsa_pkg::CNT_W-1:0]       cnt_less2;
  logic [tmsa_pkg::DIVR_W-1:0]      divisor;
  logic                             div_start;
  tmsa_pkg::div_stat_t              div_stat;
  logic [tmsa_pkg::SUM_W-1:0]       quotient;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] q_sat;

  always_comb begin
    if (samples_per_average < tmsa_pkg::SPA_MIN) begin
      spa_clamped = tmsa_pkg::SPA_MIN;
    end else if (samples_per_average > tmsa_pkg::SPA_MAX) begin
      spa_clamped = tmsa_pkg::SPA_MAX;
    end else begin
      spa_clamped = samples_per_average;
    end
  end

  assign block_n   = tmsa_pkg::CNT_W'(spa_clamped);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // accumulation of one sample
  assign take     = (settle_left == '0) && (samples_taken < block_n);
  assign sum_wide = {1'b0, running_sum} + (tmsa_pkg::SUM_W+1)'(sample);
  assign sum_next = sum_wide[tmsa_pkg::SUM_W] ? '1 : sum_wide[tmsa_pkg::SUM_W-1:0];
  assign cnt_next = take ? (samples_taken + 1'b1) : samples_taken;
  assign min_next = (tmsa_pkg::MIN_W'(sample) < running_min) ? tmsa_pkg::MIN_W'(sample)
                                                               : running_min;
  assign max_next = (sample > running_max) ? sample : running_max;
  assign complete = cnt_next >= block_n;

  // trimmed difference and divisor
  assign trim      = tmsa_pkg::TRIM_W'(running_min) + tmsa_pkg::TRIM_W'(running_max);
  assign trim_ext  = tmsa_pkg::SUM_W'(trim);
  assign diff      = (running_sum > trim_ext) ? (running_sum - trim_ext) : '0;
  assign cnt_less2 = samples_taken - tmsa_pkg::CNT_W'(2);
  assign divisor   = cnt_less2[tmsa_pkg::DIVR_W-1:0];
  assign div_start = (state == S_PREP);

  assign q_sat = (quotient > tmsa_pkg::SUM_W'(tmsa_pkg::SAMPLE_MASK))
                 ? tmsa_pkg::SAMPLE_MASK : quotient[tmsa_pkg::SAMPLE_BITS-1:0];

  tmsa_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      samples_per_average <= tmsa_pkg::SPA_RESET;
      min_start           <= tmsa_pkg::MIN_START_RESET;
      max_start           <= tmsa_pkg::MAX_START_RESET;
      settle_ticks        <= tmsa_pkg::SETTLE_RESET;
      running_sum         <= '0;
      samples_taken       <= '0;
      running_min         <= tmsa_pkg::MIN_START_RESET;
      running_max         <= '0;
      held_average        <= '0;
      settle_left         <= '0;
      pend_updated        <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tmsa_pkg::REG_SPA:       samples_per_average <= cfg_data[tmsa_pkg::SPA_W-1:0];
          tmsa_pkg::REG_MIN_START: min_start <= cfg_data[tmsa_pkg::MIN_W-1:0];
          tmsa_pkg::REG_MAX_START: max_start <= cfg_data[tmsa_pkg::SAMPLE_BITS-1:0];
          tmsa_pkg::REG_SETTLE:    settle_ticks <= cfg_data[tmsa_pkg::SETTLE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!sensing_on) begin
              settle_left   <= settle_ticks;
              running_sum   <= '0;
              samples_taken <= '0;
              running_min   <= min_start;
              running_max   <= max_start;
            end else begin
              if (settle_left != '0) begin
                settle_left <= settle_left - 1'b1;
              end
              if (take) begin
                running_sum   <= sum_next;
                samples_taken <= cnt_next;
                running_min   <= min_next;
                running_max   <= max_next;
              end
            end
            if (sensing_on && complete) begin
              state <= S_PREP;
            end else if (slot_free) begin
              out_valid       <= 1'b1;
              average         <= held_average;
              average_updated <= 1'b0;
            end else begin
              pend_updated <= 1'b0;
              state        <= S_OUT;
            end
          end
        end
        S_PREP: begin
          // divider latches the trimmed difference, block restarts
          running_sum   <= '0;
          samples_taken <= '0;
          running_min   <= min_start;
          running_max   <= max_start;
          state         <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            held_average <= q_sat;
            pend_updated <= 1'b1;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid       <= 1'b1;
            average         <= held_average;
            average_updated <= pend_updated;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TMSA_ASSERT_SAME(a_busy_blocks_input, div_stat.busy, !in_ready, "input taken while dividing")
  `TMSA_ASSERT_SAME(a_count_range, 1'b1, samples_taken <= tmsa_pkg::CNT_W'(tmsa_pkg::MAX_SAMPLES), "sample count out of range")
  `TMSA_ASSERT_NEXT(a_done_to_out, div_stat.done, state == S_OUT, "division result not delivered")

endmodule

// File: src/tmsa_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module tmsa_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tmsa_pkg::SUM_W-1:0]  dividend,
  input  logic [tmsa_pkg::DIVR_W-1:0] divisor,
  output tmsa_pkg::div_stat_t         stat,
  output logic [tmsa_pkg::SUM_W-1:0]  quotient
);

  logic [tmsa_pkg::SUM_W-1:0]  dq;
  logic [tmsa_pkg::DIVR_W:0]   rem;
  logic [tmsa_pkg::DIVR_W-1:0] divisor_r;
  logic [tmsa_pkg::STEP_W-1:0] steps;
  logic                        busy;
  logic                        done;
  logic [tmsa_pkg::DIVR_W:0]   rem_sh;
  logic [tmsa_pkg::DIVR_W:0]   divisor_ext;
  logic                        ge;
  logic [tmsa_pkg::DIVR_W:0]   rem_next;

  assign rem_sh      = {rem[tmsa_pkg::DIVR_W-1:0], dq[tmsa_pkg::SUM_W-1]};
  assign divisor_ext = {1'b0, divisor_r};
  assign ge          = rem_sh >= divisor_ext;
  assign rem_next    = ge ? (rem_sh - divisor_ext) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq        <= dividend;
        rem       <= '0;
        divisor_r <= divisor;
        steps     <= tmsa_pkg::STEP_W'(tmsa_pkg::DIV_STEPS);
        busy      <= 1'b1;
      end else if (busy) begin
        dq    <= {dq[tmsa_pkg::SUM_W-2:0], ge};
        rem   <= rem_next;
        steps <= steps - 1'b1;
        if (steps == tmsa_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dq;

endmodule

// File: tb/tb_trimmed_mean_sample_averager_unit.sv
// self-checking testbench for the trimmed mean sample averager with a tick-level predictor
`timescale 1ns / 1ps

module tb_trimmed_mean_sample_averager_unit;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_TICKS = 1750;

  typedef struct {
    logic [tmsa_pkg::SAMPLE_BITS-1:0] sample;
    logic                             sensing;
  } sample_tick_t;

  typedef struct {
    logic [tmsa_pkg::SAMPLE_BITS-1:0] average;
    logic                             updated;
  } average_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic                             sensing_on = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] average;
  logic                             average_updated;
  logic                             cfg_we = 1'b0;
  logic [tmsa_pkg::IDX_W-1:0]       cfg_index = '0;
  logic [tmsa_pkg::CFG_W-1:0]       cfg_data = '0;

  sample_tick_t    pending_ticks[$];
  average_result_t expected_averages[$];
  logic            in_fire = 1'b0;
  int unsigned     src_idle_pct = 0;
  int unsigned     sink_stall_pct = 0;
  int unsigned     ticks_queued = 0;
  int unsigned     ticks_accepted = 0;
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;

  // register mirror
  logic [tmsa_pkg::SPA_W-1:0]       cfg_spa = tmsa_pkg::SPA_RESET;
  logic [tmsa_pkg::MIN_W-1:0]       cfg_min_start = tmsa_pkg::MIN_START_RESET;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] cfg_max_start = tmsa_pkg::MAX_START_RESET;
  logic [tmsa_pkg::SETTLE_W-1:0]    cfg_settle = tmsa_pkg::SETTLE_RESET;

  // averager state mirror
  logic [tmsa_pkg::SUM_W-1:0]       acc_sum = '0;
  logic [tmsa_pkg::CNT_W-1:0]       taken = '0;
  logic [tmsa_pkg::MIN_W-1:0]       run_min = tmsa_pkg::MIN_START_RESET;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] run_max = '0;
  logic [tmsa_pkg::SAMPLE_BITS-1:0] held_avg = '0;
  logic [tmsa_pkg::SETTLE_W-1:0]    settle_left = '0;

  trimmed_mean_sample_averager_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .sensing_on      (sensing_on),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .average         (average),
    .average_updated (average_updated),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic clear_block();
    acc_sum = '0;
    taken   = '0;
    run_min = cfg_min_start;
    run_max = cfg_max_start;
  endtask

  task automatic predict_average(input logic [tmsa_pkg::SAMPLE_BITS-1:0] smp,
                                 input logic sensing, output average_result_t res);
    logic [tmsa_pkg::CNT_W-1:0]  n;
    logic [tmsa_pkg::SUM_W:0]    sum_wide;
    logic [tmsa_pkg::TRIM_W-1:0] trim;
    logic [tmsa_pkg::SUM_W-1:0]  diff;
    logic [tmsa_pkg::SUM_W-1:0]  quot;
    n = tmsa_pkg::CNT_W'(cfg_spa);
    if (n < tmsa_pkg::CNT_W'(tmsa_pkg::SPA_MIN)) n = tmsa_pkg::CNT_W'(tmsa_pkg::SPA_MIN);
    if (n > tmsa_pkg::CNT_W'(tmsa_pkg::MAX_SAMPLES)) begin
      n = tmsa_pkg::CNT_W'(tmsa_pkg::MAX_SAMPLES);
    end
    res.updated = 1'b0;
    if (!sensing) begin
      settle_left = cfg_settle;
      clear_block();
    end else begin
      if (settle_left != '0) begin
        settle_left = settle_left - 1'b1;
      end else if (taken < n) begin
        sum_wide = acc_sum + smp;
        acc_sum = sum_wide[tmsa_pkg::SUM_W] ? '1 : sum_wide[tmsa_pkg::SUM_W-1:0];
        taken = taken + 1'b1;
        if (tmsa_pkg::MIN_W'(smp) < run_min) run_min = tmsa_pkg::MIN_W'(smp);
        if (smp > run_max) run_max = smp;
      end
      if (taken >= n) begin
        trim = tmsa_pkg::TRIM_W'(run_min) + tmsa_pkg::TRIM_W'(run_max);
        diff = (tmsa_pkg::SUM_W'(acc_sum) > tmsa_pkg::SUM_W'(trim))
               ? acc_sum - tmsa_pkg::SUM_W'(trim) : '0;
        quot = diff / tmsa_pkg::SUM_W'(taken - 2'd2);
        held_avg = (quot > tmsa_pkg::SUM_W'(tmsa_pkg::SAMPLE_MASK))
                   ? tmsa_pkg::SAMPLE_MASK : quot[tmsa_pkg::SAMPLE_BITS-1:0];
        res.updated = 1'b1;
        clear_block();
      end
    end
    res.average = held_avg;
  endtask

  // input driver
  always @(negedge clk) begin
    sample_tick_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        t = pending_ticks.pop_front();
        in_valid   <= 1'b1;
        sample     <= t.sample;
        sensing_on <= t.sensing;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // output monitor and prediction
  always @(posedge clk) begin
    average_result_t got;
    average_result_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_averages.size() == 0) begin
          $error("unexpected output item: average %0d average_updated %0d",
                 average, average_updated);
          error_count++;
        end else begin
          want = expected_averages.pop_front();
          if (average !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, average);
            error_count++;
          end
          if (average_updated !== want.updated) begin
            $error("average_updated: expected %0d, actual %0d", want.updated,
                   average_updated);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_average(sample, sensing_on, got);
        expected_averages.push_back(got);
        ticks_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input tmsa_pkg::cfg_reg_t idx,
                           input logic [tmsa_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      tmsa_pkg::REG_SPA:       cfg_spa = val[tmsa_pkg::SPA_W-1:0];
      tmsa_pkg::REG_MIN_START: cfg_min_start = val[tmsa_pkg::MIN_W-1:0];
      tmsa_pkg::REG_MAX_START: cfg_max_start = val[tmsa_pkg::SAMPLE_BITS-1:0];
      tmsa_pkg::REG_SETTLE:    cfg_settle = val[tmsa_pkg::SETTLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [tmsa_pkg::CFG_W-1:0] spa,
                            input logic [tmsa_pkg::CFG_W-1:0] mn,
                            input logic [tmsa_pkg::CFG_W-1:0] mx,
                            input logic [tmsa_pkg::CFG_W-1:0] st);
    write_reg(tmsa_pkg::REG_SPA, spa);
    write_reg(tmsa_pkg::REG_MIN_START, mn);
    write_reg(tmsa_pkg::REG_MAX_START, mx);
    write_reg(tmsa_pkg::REG_SETTLE, st);
    @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
      default: begin src_idle_pct = 30; sink_stall_pct = 30; end
    endcase
  endtask

  task automatic queue_tick(input logic [tmsa_pkg::SAMPLE_BITS-1:0] smp, input logic sensing);
    sample_tick_t t;
    t.sample  = smp;
    t.sensing = sensing;
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  task automatic queue_block(input int unsigned a, input int unsigned b, input int unsigned c);
    queue_tick(tmsa_pkg::SAMPLE_BITS'(a), 1'b1);
    queue_tick(tmsa_pkg::SAMPLE_BITS'(b), 1'b1);
    queue_tick(tmsa_pkg::SAMPLE_BITS'(c), 1'b1);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (ticks_accepted != ticks_queued || expected_averages.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [tmsa_pkg::SAMPLE_BITS-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return tmsa_pkg::SAMPLE_MASK;
    return tmsa_pkg::SAMPLE_BITS'($urandom_range(1023));
  endfunction

  function automatic logic [tmsa_pkg::CFG_W-1:0] pick_block_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return tmsa_pkg::CFG_W'($urandom_range(3, 12));
    if (r < 80) return tmsa_pkg::CFG_W'($urandom_range(13, 64));
    if (r < 90) return tmsa_pkg::CFG_W'($urandom_range(0, 2));
    if (r < 95) return tmsa_pkg::CFG_W'($urandom_range(65, 127));
    return tmsa_pkg::CFG_W'($urandom());
  endfunction

  function automatic logic [tmsa_pkg::CFG_W-1:0] pick_min_start();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return tmsa_pkg::CFG_W'(tmsa_pkg::MIN_START_RESET);
    if (r < 70) return tmsa_pkg::CFG_W'($urandom_range(1023));
    if (r < 85) return tmsa_pkg::CFG_W'($urandom());
    return '0;
  endfunction

  function automatic logic [tmsa_pkg::CFG_W-1:0] pick_max_start();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return '0;
    if (r < 75) return tmsa_pkg::CFG_W'($urandom_range(1023));
    if (r < 90) return tmsa_pkg::CFG_W'(tmsa_pkg::SAMPLE_MASK);
    return tmsa_pkg::CFG_W'($urandom());
  endfunction

  function automatic logic [tmsa_pkg::CFG_W-1:0] pick_settle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return '0;
    if (r < 95) return tmsa_pkg::CFG_W'($urandom_range(1, 6));
    return tmsa_pkg::CFG_W'($urandom_range(7, 20));
  endfunction

  initial begin
    int unsigned random_ticks;
    int unsigned phase;
    int unsigned len;
    logic        force_off;
    random_ticks = 0;
    phase = 0;
    force_off = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idling(0);

    // block size below three, full-scale and zero samples
    set_config(tmsa_pkg::CFG_W'(0), tmsa_pkg::CFG_W'(tmsa_pkg::MIN_START_RESET), '0, '0);
    queue_tick('0, 1'b0);
    queue_block(0, 1023, 512);
    queue_block(1023, 1023, 1023);
    queue_block(0, 0, 0);
    wait_idle();

    // widest block size, left partly filled
    set_config(tmsa_pkg::CFG_W'(127), tmsa_pkg::CFG_W'(tmsa_pkg::MIN_START_RESET), '0, '0);
    queue_block(1, 2, 3);
    queue_tick(tmsa_pkg::SAMPLE_BITS'(4), 1'b1);
    queue_tick(tmsa_pkg::SAMPLE_BITS'(5), 1'b1);
    wait_idle();

    // lowered block size closes the open block, then overflow and negative trim
    set_config(tmsa_pkg::CFG_W'(tmsa_pkg::SPA_MIN), '0,
               tmsa_pkg::CFG_W'(tmsa_pkg::SAMPLE_MASK), '0);
    queue_tick(tmsa_pkg::SAMPLE_BITS'(700), 1'b1);
    queue_block(1023, 1023, 1023);
    queue_block(1, 2, 3);
    wait_idle();

    // longest settle countdown
    set_config(tmsa_pkg::CFG_W'(tmsa_pkg::SPA_MAX),
               tmsa_pkg::CFG_W'(tmsa_pkg::MIN_START_RESET), '0, '1);
    queue_tick(tmsa_pkg::SAMPLE_BITS'(9), 1'b0);
    queue_block(9, 9, 9);
    wait_idle();

    while (random_ticks < RANDOM_TICKS) begin
      set_idling(phase % 4);
      set_config(pick_block_size(), pick_min_start(), pick_max_start(), pick_settle());
      len = $urandom_range(40, 120);
      if (force_off || $urandom_range(1) == 0) queue_tick(pick_sample(), 1'b0);
      repeat (len) queue_tick(pick_sample(), $urandom_range(99) >= 3);
      random_ticks += len;
      force_off = 1'b0;
      phase++;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/tmsa_pkg.sv
src/tmsa_divider.sv
src/trimmed_mean_sample_averager_unit.sv
tb/tb_trimmed_mean_sample_averager_unit.sv
